// ===== hw/rtl/kmst_pkg.sv =====
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the spanning tree weight core.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int NUM_VERT   = 1024;
  localparam int VERT_BITS  = $clog2(NUM_VERT);
  localparam int NUM_EDGES  = 4096;
  localparam int EADDR_BITS = $clog2(NUM_EDGES);
  localparam int CNT_BITS   = EADDR_BITS + 1;
  localparam int PORT_BITS  = 11;
  localparam int W_BITS     = 16;
  localparam int SIZE_BITS  = VERT_BITS + 1;
  localparam int SUM_BITS   = 26;
  localparam int EDGE_BITS  = 2 * VERT_BITS + W_BITS;

  typedef struct packed {
    logic [VERT_BITS-1:0]    va;
    logic [VERT_BITS-1:0]    vb;
    logic signed [W_BITS-1:0] w;
  } edge_t;

  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] n;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_SOLVE,
    ST_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    SS_IDLE,
    SS_BLD_RD,
    SS_BLD_CAP,
    SS_EX_RD0,
    SS_EX_RD1,
    SS_EX_WR,
    SS_L0,
    SS_L1,
    SS_L2,
    SS_END
  } sort_state_t;

  typedef enum logic [3:0] {
    US_IDLE,
    US_INIT,
    US_ERD,
    US_ECAP,
    US_F1,
    US_F1C,
    US_F2C,
    US_SZ0,
    US_SZ1,
    US_SZ2,
    US_NEXT
  } uf_state_t;

endpackage

// ===== hw/rtl/kmst_ram.sv =====
// ----------------------------------------------------------------------------
// kmst_ram
// Generic memory, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kmst_heap_sort.sv =====
// ----------------------------------------------------------------------------
// kmst_heap_sort
// In-place heap sort of the edge memory by ascending weight.
// ----------------------------------------------------------------------------
module kmst_heap_sort (
  input  logic                               clk,
  input  logic                               rst,
  input  kmst_pkg::unit_ctl_t                ctl,
  output kmst_pkg::unit_status_t             status,
  output logic [kmst_pkg::EADDR_BITS-1:0]    rd_addr,
  input  kmst_pkg::edge_t                    rd_data,
  output logic                               wr_en,
  output logic [kmst_pkg::EADDR_BITS-1:0]    wr_addr,
  output kmst_pkg::edge_t                    wr_data
);
  import kmst_pkg::*;

  sort_state_t           state, state_next;
  logic [EADDR_BITS-1:0] i, i_next;
  logic [EADDR_BITS-1:0] p, p_next;
  logic [CNT_BITS-1:0]   hn, hn_next;
  logic                  extract, extract_next;
  edge_t                 pe, pe_next;
  edge_t                 le, le_next;
  logic [CNT_BITS-1:0]   l_idx, r_idx;
  logic                  done;

  assign l_idx = {p, 1'b1};
  assign r_idx = l_idx + CNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
    end else begin
      state <= state_next;
    end
    i       <= i_next;
    p       <= p_next;
    hn      <= hn_next;
    extract <= extract_next;
    pe      <= pe_next;
    le      <= le_next;
  end

  always_comb begin
    state_next   = state;
    i_next       = i;
    p_next       = p;
    hn_next      = hn;
    extract_next = extract;
    pe_next      = pe;
    le_next      = le;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = p;
    wr_data      = pe;
    done         = 1'b0;
    unique case (state)
      SS_IDLE: begin
        if (ctl.start) begin
          if (ctl.n < CNT_BITS'(2)) begin
            done = 1'b1;
          end else begin
            i_next       = ctl.n[CNT_BITS-1:1];
            extract_next = 1'b0;
            state_next   = SS_BLD_RD;
          end
        end
      end
      SS_BLD_RD: begin
        rd_addr    = i - EADDR_BITS'(1);
        state_next = SS_BLD_CAP;
      end
      SS_BLD_CAP: begin
        pe_next    = rd_data;
        p_next     = i - EADDR_BITS'(1);
        hn_next    = ctl.n;
        state_next = SS_L0;
      end
      SS_EX_RD0: begin
        rd_addr    = '0;
        state_next = SS_EX_RD1;
      end
      SS_EX_RD1: begin
        le_next    = rd_data;
        rd_addr    = i;
        state_next = SS_EX_WR;
      end
      SS_EX_WR: begin
        pe_next    = rd_data;
        wr_en      = 1'b1;
        wr_addr    = i;
        wr_data    = le;
        p_next     = '0;
        hn_next    = {1'b0, i};
        state_next = SS_L0;
      end
      SS_L0: begin
        rd_addr = l_idx[EADDR_BITS-1:0];
        if (l_idx < hn) begin
          state_next = SS_L1;
        end else begin
          state_next = SS_END;
        end
      end
      SS_L1: begin
        le_next    = rd_data;
        rd_addr    = r_idx[EADDR_BITS-1:0];
        state_next = SS_L2;
      end
      SS_L2: begin
        priority if ((r_idx < hn) && (rd_data.w > le.w) && (rd_data.w > pe.w)) begin
          wr_en      = 1'b1;
          wr_data    = rd_data;
          p_next     = r_idx[EADDR_BITS-1:0];
          state_next = SS_L0;
        end else if (le.w > pe.w) begin
          wr_en      = 1'b1;
          wr_data    = le;
          p_next     = l_idx[EADDR_BITS-1:0];
          state_next = SS_L0;
        end else begin
          state_next = SS_END;
        end
      end
      SS_END: begin
        wr_en = 1'b1;
        if (i == EADDR_BITS'(1)) begin
          if (extract) begin
            done       = 1'b1;
            state_next = SS_IDLE;
          end else begin
            extract_next = 1'b1;
            i_next       = EADDR_BITS'(ctl.n - CNT_BITS'(1));
            state_next   = SS_EX_RD0;
          end
        end else begin
          i_next = i - EADDR_BITS'(1);
          if (extract) begin
            state_next = SS_EX_RD0;
          end else begin
            state_next = SS_BLD_RD;
          end
        end
      end
      default: state_next = SS_IDLE;
    endcase
  end

  assign status.busy = (state != SS_IDLE);
  assign status.done = done;

endmodule

// ===== hw/rtl/kmst_union_find.sv =====
// ----------------------------------------------------------------------------
// kmst_union_find
// Walks the sorted edges through a union-find store and sums joining weights.
// ----------------------------------------------------------------------------
module kmst_union_find (
  input  logic                                  clk,
  input  logic                                  rst,
  input  kmst_pkg::unit_ctl_t                   ctl,
  output kmst_pkg::unit_status_t                status,
  output logic [kmst_pkg::EADDR_BITS-1:0]       rd_addr,
  input  kmst_pkg::edge_t                       rd_data,
  output logic signed [kmst_pkg::SUM_BITS-1:0]  sum
);
  import kmst_pkg::*;

  uf_state_t             state, state_next;
  logic [VERT_BITS-1:0]  k, k_next;
  logic [EADDR_BITS-1:0] e, e_next;
  edge_t                 erec, erec_next;
  logic [VERT_BITS-1:0]  v, v_next;
  logic [VERT_BITS-1:0]  r, r_next;
  logic [VERT_BITS-1:0]  x, x_next;
  logic                  side, side_next;
  logic [SIZE_BITS-1:0]  sx, sx_next;
  logic signed [SUM_BITS-1:0] sum_next;
  logic                  done;

  logic                  root_we;
  logic [VERT_BITS-1:0]  root_waddr, root_wdata, root_raddr, root_rdata;
  logic                  size_we;
  logic [VERT_BITS-1:0]  size_waddr, size_raddr;
  logic [SIZE_BITS-1:0]  size_wdata, size_rdata;

  kmst_ram #(.WIDTH(VERT_BITS), .DEPTH(NUM_VERT)) u_root (
    .clk   (clk),
    .we    (root_we),
    .waddr (root_waddr),
    .wdata (root_wdata),
    .raddr (root_raddr),
    .rdata (root_rdata)
  );

  kmst_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_VERT)) u_size (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= US_IDLE;
      sum   <= '0;
    end else begin
      state <= state_next;
      sum   <= sum_next;
    end
    k    <= k_next;
    e    <= e_next;
    erec <= erec_next;
    v    <= v_next;
    r    <= r_next;
    x    <= x_next;
    side <= side_next;
    sx   <= sx_next;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    e_next     = e;
    erec_next  = erec;
    v_next     = v;
    r_next     = r;
    x_next     = x;
    side_next  = side;
    sx_next    = sx;
    sum_next   = sum;
    done       = 1'b0;
    rd_addr    = e;
    root_we    = 1'b0;
    root_waddr = v;
    root_wdata = r;
    root_raddr = r;
    size_we    = 1'b0;
    size_waddr = x;
    size_wdata = '0;
    size_raddr = x;
    unique case (state)
      US_IDLE: begin
        if (ctl.start) begin
          k_next     = '0;
          sum_next   = '0;
          state_next = US_INIT;
        end
      end
      US_INIT: begin
        root_we    = 1'b1;
        root_waddr = k;
        root_wdata = k;
        size_we    = 1'b1;
        size_waddr = k;
        size_wdata = SIZE_BITS'(1);
        k_next     = k + VERT_BITS'(1);
        if (&k) begin
          e_next = '0;
          if (ctl.n == '0) begin
            done       = 1'b1;
            state_next = US_IDLE;
          end else begin
            state_next = US_ERD;
          end
        end
      end
      US_ERD: begin
        state_next = US_ECAP;
      end
      US_ECAP: begin
        erec_next  = rd_data;
        v_next     = rd_data.va;
        r_next     = rd_data.va;
        side_next  = 1'b0;
        state_next = US_F1;
      end
      US_F1: begin
        state_next = US_F1C;
      end
      US_F1C: begin
        if (root_rdata == r) begin
          root_raddr = v;
          state_next = US_F2C;
        end else begin
          r_next     = root_rdata;
          root_raddr = root_rdata;
        end
      end
      US_F2C: begin
        if (root_rdata == r) begin
          if (!side) begin
            x_next     = r;
            v_next     = erec.vb;
            r_next     = erec.vb;
            side_next  = 1'b1;
            state_next = US_F1;
          end else begin
            state_next = US_SZ0;
          end
        end else begin
          root_we    = 1'b1;
          v_next     = root_rdata;
          root_raddr = root_rdata;
        end
      end
      US_SZ0: begin
        size_raddr = x;
        if (x == r) begin
          state_next = US_NEXT;
        end else begin
          state_next = US_SZ1;
        end
      end
      US_SZ1: begin
        sx_next    = size_rdata;
        size_raddr = r;
        state_next = US_SZ2;
      end
      US_SZ2: begin
        root_we    = 1'b1;
        size_we    = 1'b1;
        size_wdata = sx + size_rdata;
        if (sx < size_rdata) begin
          root_waddr = x;
          root_wdata = r;
          size_waddr = r;
        end else begin
          root_waddr = r;
          root_wdata = x;
          size_waddr = x;
        end
        sum_next   = sum + SUM_BITS'(erec.w);
        state_next = US_NEXT;
      end
      US_NEXT: begin
        if (({1'b0, e} + CNT_BITS'(1)) == ctl.n) begin
          done       = 1'b1;
          state_next = US_IDLE;
        end else begin
          e_next     = e + EADDR_BITS'(1);
          state_next = US_ERD;
        end
      end
      default: state_next = US_IDLE;
    endcase
  end

  assign status.busy = (state != US_IDLE);
  assign status.done = done;

endmodule

// ===== hw/rtl/kruskal_mst_weight_core.sv =====
// ----------------------------------------------------------------------------
// kruskal_mst_weight_core
// Minimum spanning forest weight of a graph loaded one edge per request.
// ----------------------------------------------------------------------------
// Edges load one per cycle into a 4096-entry edge memory. The request that
// carries last_edge closes the graph; the core then stops taking requests,
// heap-sorts the stored edges in place through the one read port and one
// write port of the edge memory, sets up the union-find store for all 1024
// vertices, and runs one find-and-union pass for each edge, following the
// pointers of both ends to their roots. The one result then waits on the
// output until taken, after which loading resumes.
module kruskal_mst_weight_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [kmst_pkg::PORT_BITS-1:0]       cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kmst_pkg::PORT_BITS-1:0]       end_a,
  input  logic [kmst_pkg::PORT_BITS-1:0]       end_b,
  input  logic signed [kmst_pkg::W_BITS-1:0]   edge_weight,
  input  logic                                 last_edge,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [kmst_pkg::SUM_BITS-1:0] tree_weight,
  output logic                                 edges_dropped
);
  import kmst_pkg::*;

  top_state_t            state, state_next;
  logic [PORT_BITS-1:0]  vertex_count;
  logic [CNT_BITS-1:0]   edge_count;
  logic [CNT_BITS-1:0]   n_total;
  logic                  overflow_seen;
  logic [PORT_BITS-1:0]  limit;
  logic                  accept, edge_ok, store_ok;

  unit_ctl_t             sort_ctl, uf_ctl;
  unit_status_t          sort_st, uf_st;
  logic [EADDR_BITS-1:0] sort_raddr, uf_raddr, e_raddr, e_waddr;
  logic [EADDR_BITS-1:0] sort_raddr_w;
  logic                  sort_we, e_we;
  edge_t                 sort_wdata, e_wdata, e_rdata, load_edge;

  assign limit    = (vertex_count > PORT_BITS'(NUM_VERT)) ? PORT_BITS'(NUM_VERT) : vertex_count;
  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign edge_ok  = (end_a != '0) && (end_b != '0) && (end_a <= limit) && (end_b <= limit);
  assign store_ok = edge_count < CNT_BITS'(NUM_EDGES);
  assign n_total  = edge_count + CNT_BITS'(accept && edge_ok && store_ok);

  assign load_edge.va = VERT_BITS'(end_a - PORT_BITS'(1));
  assign load_edge.vb = VERT_BITS'(end_b - PORT_BITS'(1));
  assign load_edge.w  = edge_weight;

  assign e_we    = (state == ST_LOAD) ? (accept && edge_ok && store_ok) : sort_we;
  assign e_waddr = (state == ST_LOAD) ? edge_count[EADDR_BITS-1:0] : sort_raddr_w;
  assign e_wdata = (state == ST_LOAD) ? load_edge : sort_wdata;
  assign e_raddr = (state == ST_SORT) ? sort_raddr : uf_raddr;

  kmst_ram #(.WIDTH(EDGE_BITS), .DEPTH(NUM_EDGES)) u_edges (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign sort_ctl.start = accept && last_edge;
  assign sort_ctl.n     = n_total;
  assign uf_ctl.start   = sort_st.done;
  assign uf_ctl.n       = edge_count;

  kmst_heap_sort u_sort (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sort_ctl),
    .status  (sort_st),
    .rd_addr (sort_raddr),
    .rd_data (e_rdata),
    .wr_en   (sort_we),
    .wr_addr (sort_raddr_w),
    .wr_data (sort_wdata)
  );

  kmst_union_find u_uf (
    .clk     (clk),
    .rst     (rst),
    .ctl     (uf_ctl),
    .status  (uf_st),
    .rd_addr (uf_raddr),
    .rd_data (e_rdata),
    .sum     (tree_weight)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      vertex_count  <= PORT_BITS'(NUM_VERT);
      edge_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (accept && edge_ok) begin
        if (store_ok) begin
          edge_count <= edge_count + CNT_BITS'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if ((state == ST_OUT) && !out_stall) begin
        edge_count    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last_edge) begin
          state_next = sort_st.done ? ST_SOLVE : ST_SORT;
        end
      end
      ST_SORT:  if (sort_st.done) state_next = ST_SOLVE;
      ST_SOLVE: if (uf_st.done) state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  assign out_valid     = (state == ST_OUT);
  assign edges_dropped = overflow_seen;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CNT_BITS'(NUM_EDGES))
    else $error("edge count beyond store depth");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    accept && last_edge |=> in_stall && !out_valid)
    else $error("graph not closed after last edge");

  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !(sort_st.busy && uf_st.busy))
    else $error("sort and union-find active together");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tree_weight))
    else $error("result lost while stalled");

endmodule
